// ----- hw/rtl/proxy_secret_classifier_assert.svh -----
// ----------------------------------------------------------------------------
// Proxy secret classifier assertion macros
// Shared concurrent assertion forms, clocked on aclk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef PROXY_SECRET_CLASSIFIER_ASSERT_SVH
`define PROXY_SECRET_CLASSIFIER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("proxy_secret_classifier: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PSC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("proxy_secret_classifier: assertion failed");

`endif

// ----- hw/rtl/psc_pkg.sv -----
// ----------------------------------------------------------------------------
// Proxy secret classifier package
// Limits, status codes, shared types and the classification functions.
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam int DOMAIN_MAX  = 182;
    localparam int KEEP_LIMIT  = 17 + DOMAIN_MAX;
    localparam int CNT_BITS    = $clog2(KEEP_LIMIT + 1);
    localparam int CNT_W       = (CNT_BITS > 8) ? CNT_BITS : 8;
    localparam int LABEL_MAX   = 63;
    localparam int LABEL_W     = 7;
    localparam int HOST_START  = 17;
    localparam int PLAIN_LEN   = 16;
    localparam int PADDED_LEN  = 17;
    localparam int TLS_MIN_LEN = 18;

    localparam logic [7:0] PADDED_MARK = 8'hdd;
    localparam logic [7:0] TLS_MARK    = 8'hee;
    localparam logic [7:0] DOT_CHAR    = 8'h2e;
    localparam logic [7:0] HYPHEN_CHAR = 8'h2d;

    localparam int ADDR_W = 3;
    localparam logic [0:0] REG_TRUNCATE_LONG = 1'b0;

    typedef enum logic [2:0] {
        ST_PLAIN       = 3'd0,
        ST_PADDED      = 3'd1,
        ST_TLS         = 3'd2,
        ST_WRONG       = 3'd3,
        ST_TOO_LONG    = 3'd4,
        ST_UNSUPPORTED = 3'd5
    } status_t;

    typedef struct packed {
        logic en;
        logic clr;
    } host_ctrl_t;

    function automatic logic host_char_ok(input logic [7:0] b);
        return (b inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a], HYPHEN_CHAR});
    endfunction

    function automatic status_t classify(
        input logic             ovf,
        input logic             trunc,
        input logic [CNT_W-1:0] n,
        input logic [7:0]       first,
        input logic             host_ok
    );
        status_t st;
        if (ovf && !trunc) begin
            st = ST_TOO_LONG;
        end else if (n == CNT_W'(PLAIN_LEN)) begin
            st = ST_PLAIN;
        end else if (n == CNT_W'(PADDED_LEN) && first == PADDED_MARK) begin
            st = ST_PADDED;
        end else if (n >= CNT_W'(TLS_MIN_LEN) && first == TLS_MARK) begin
            st = host_ok ? ST_TLS : ST_WRONG;
        end else if (n < CNT_W'(PLAIN_LEN)) begin
            st = ST_WRONG;
        end else begin
            st = ST_UNSUPPORTED;
        end
        return st;
    endfunction

endpackage

// ----- hw/rtl/proxy_secret_classifier.sv -----
// ----------------------------------------------------------------------------
// Proxy secret classifier
// Classifies a decoded proxy secret streamed one byte per request.
// ----------------------------------------------------------------------------
// The slave stream takes one secret byte per request, with tlast on the final
// byte. Each byte updates the length counter and hostname checks in the cycle
// it is accepted, so a new byte can be taken every cycle unless stalled. The
// request with tlast produces one result on the master stream in the next
// cycle, carrying the status code and the kept length; other bytes give none.
// The result sits in an output register; the slave side keeps accepting
// while that register is free or being emptied in the same cycle, and stalls
// only while a result waits and the receiver holds tready low.
// Bytes beyond 17 plus the domain limit are not examined: the secret is then
// reported too long, or truncated when the truncate_long register is set.
// The APB port holds truncate_long at address 0; write it only while idle.
// Reset clears the counters, the hostname state, the register and any
// pending result; after each final byte the scan state returns to reset.
// ----------------------------------------------------------------------------
module proxy_secret_classifier (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] secret_byte
    input  logic                        s_tlast,   // last_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // [2:0] status, [10:3] kept_length
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [psc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic                        truncate_long;
    logic                        acc;
    logic                        in_keep;
    logic                        host_ok;
    psc_pkg::host_ctrl_t         host_ctrl;
    logic [psc_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [7:0]                  first_reg, first_next;
    logic                        ovf_reg, ovf_next;
    logic                        out_valid_reg;
    psc_pkg::status_t            status_reg, status_next;
    logic [7:0]                  kept_reg;

    psc_cfg u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .truncate_long (truncate_long)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign acc      = s_tvalid && s_tready;
    assign in_keep  = cnt_reg < psc_pkg::CNT_W'(psc_pkg::KEEP_LIMIT);

    assign host_ctrl.en  = acc && in_keep && (cnt_reg >= psc_pkg::CNT_W'(psc_pkg::HOST_START));
    assign host_ctrl.clr = acc && s_tlast;

    psc_host u_host (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (host_ctrl),
        .host_byte (s_tdata),
        .host_ok   (host_ok)
    );

    assign cnt_next    = in_keep ? cnt_reg + 1'b1 : cnt_reg;
    assign first_next  = (cnt_reg == '0) ? s_tdata : first_reg;
    assign ovf_next    = ovf_reg || !in_keep;
    assign status_next = psc_pkg::classify(ovf_next, truncate_long, cnt_next,
                                           first_next, host_ok);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            first_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (acc) begin
            if (s_tlast) begin
                cnt_reg   <= '0;
                first_reg <= '0;
                ovf_reg   <= 1'b0;
            end else begin
                cnt_reg   <= cnt_next;
                first_reg <= first_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (acc && s_tlast) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc && s_tlast) begin
            status_reg <= status_next;
            kept_reg   <= cnt_next[7:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, kept_reg, status_reg};

`include "proxy_secret_classifier_assert.svh"

    `PSC_ASSERT_NXT(a_result_follows_last, acc && s_tlast, out_valid_reg)
    `PSC_ASSERT_NXT(a_count_clears_after_last, acc && s_tlast, cnt_reg == '0 && !ovf_reg)
    `PSC_ASSERT_IMP(a_count_in_range, 1'b1, cnt_reg <= psc_pkg::CNT_W'(psc_pkg::KEEP_LIMIT))
    `PSC_ASSERT_IMP(a_overflow_at_limit, ovf_reg, cnt_reg == psc_pkg::CNT_W'(psc_pkg::KEEP_LIMIT))

endmodule

// ----- hw/rtl/psc_host.sv -----
// ----------------------------------------------------------------------------
// Proxy secret classifier hostname checker
// Tracks label length and hyphen rules over the hostname bytes of a secret.
// ----------------------------------------------------------------------------
module psc_host (
    input  logic                aclk,
    input  logic                aresetn,
    input  psc_pkg::host_ctrl_t ctrl,
    input  logic [7:0]          host_byte,
    output logic                host_ok
);

    logic [psc_pkg::LABEL_W-1:0] len_reg, len_next;
    logic                        start_reg, start_next;
    logic                        hyph_reg, hyph_next;
    logic                        bad_reg, bad_next;
    logic                        char_ok;

    assign char_ok = psc_pkg::host_char_ok(host_byte);

    always_comb begin
        len_next   = len_reg;
        start_next = start_reg;
        hyph_next  = hyph_reg;
        bad_next   = bad_reg;
        if (ctrl.en && !bad_reg) begin
            if (host_byte == psc_pkg::DOT_CHAR) begin
                if (len_reg == '0 || hyph_reg) begin
                    bad_next = 1'b1;
                end
                len_next   = '0;
                start_next = 1'b1;
                hyph_next  = 1'b0;
            end else if (!char_ok || (start_reg && host_byte == psc_pkg::HYPHEN_CHAR)) begin
                bad_next = 1'b1;
            end else begin
                start_next = 1'b0;
                hyph_next  = (host_byte == psc_pkg::HYPHEN_CHAR);
                len_next   = len_reg + 1'b1;
                if (len_reg >= psc_pkg::LABEL_W'(psc_pkg::LABEL_MAX)) begin
                    bad_next = 1'b1;
                end
            end
        end
    end

    assign host_ok = !bad_next && len_next != '0 && !hyph_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clr) begin
            len_reg   <= '0;
            start_reg <= 1'b1;
            hyph_reg  <= 1'b0;
            bad_reg   <= 1'b0;
        end else begin
            len_reg   <= len_next;
            start_reg <= start_next;
            hyph_reg  <= hyph_next;
            bad_reg   <= bad_next;
        end
    end

endmodule

// ----- hw/rtl/psc_cfg.sv -----
// ----------------------------------------------------------------------------
// Proxy secret classifier configuration registers
// APB-style register file holding the truncation mode.
// ----------------------------------------------------------------------------
module psc_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [psc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic                        truncate_long
);

    logic trunc_reg;
    logic sel_trunc;

    assign pready        = 1'b1;
    assign sel_trunc     = (paddr[psc_pkg::ADDR_W-1:2] == psc_pkg::REG_TRUNCATE_LONG);
    assign truncate_long = trunc_reg;
    assign prdata        = sel_trunc ? {31'd0, trunc_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trunc_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && sel_trunc) begin
            trunc_reg <= pwdata[0];
        end
    end

endmodule
